// ----- hw/rtl/pcasr_pkg.sv -----
// pcasr_pkg: shared types, constants and helpers for the PCA shape reconstruction block.
// Used by every module under hw/rtl; no dependencies.
`timescale 1ns / 1ps
package pcasr_pkg;

  // Default sizing
  localparam int MAX_COMPONENTS_DEF   = 32;
  localparam int MAX_VERTICES_DEF     = 16384;
  localparam int NUM_MEASUREMENTS_DEF = 7;

  // Field widths
  localparam int DATA_W    = 32;
  localparam int ROW_W     = 16;
  localparam int COL_W     = 5;
  localparam int KIND_W    = 3;
  localparam int IN_DATA_W = 56;  // row, col, value packed, padded to bytes
  localparam int OUT_DATA_W = 96;

  // Configuration registers
  localparam int REG_COUNT = 8;
  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam logic [2:0] REG_HEIGHT = 3'd7;
  localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
    11'd906, 11'd867, 11'd812, 11'd952, 11'd385, 11'd771, 11'd377, 11'd1740};
  localparam logic [REG_W-1:0] REG_MASK [REG_COUNT] = '{
    11'h7FF, 11'h3FF, 11'h7FF, 11'h7FF, 11'h1FF, 11'h3FF, 11'h3FF, 11'h7FF};

  // Datapath widths
  localparam int RATIO_W = 27;  // measurement / height, unsigned Q11.16
  localparam int WPROD_W = 60;  // weight times ratio
  localparam int SUM_W   = 64;
  localparam int ACC_W   = 56;  // sum of up to 32 floored Q16.16 products plus mean
  localparam int S_W     = 38;  // clamped pre-scale value; beyond it the output saturates
  localparam int P_W     = 50;  // clamped value times height
  localparam int DIV_NW  = 27;  // measurement shifted up by 16
  localparam int DIV_DW  = 11;
  localparam int FLOOR_BIAS = 9;

  // Floor division by ten: x = hi * 2^16 + lo and 2^16 = 6553 * 10 + 6
  localparam int QX_W      = 35;  // clamped dividend; anything larger saturates anyway
  localparam int QT_W      = 22;  // 6 * hi + lo
  localparam int QP_W      = 47;  // QT_W times the 25-bit reciprocal
  localparam int DIV10_HI  = 6553;
  localparam int DIV10_REM = 6;
  localparam int DIV10_RCP = 26843546;  // ceil(2^28 / 10)
  localparam int DIV10_SH  = 28;

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WEIGHT = 3'd0,
    KIND_OFFSET = 3'd1,
    KIND_BASIS  = 3'd2,
    KIND_MEAN   = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_t;

  // Query sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_RATIO_GO, S_RATIO_WAIT,
    S_W_RD, S_W_MUL, S_W_ACC, S_E_RD, S_E_ADD,
    S_B_RD, S_B_MUL, S_B_ACC,
    S_M_RD, S_M_ADD, S_H_MUL, S_Q_GO, S_Q_WAIT, S_OUT
  } state_t;

  // Clamp a signed 64-bit value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/pcasr_div.sv -----
// pcasr_div: bit-serial restoring unsigned divider, one quotient bit per cycle.
// Depends on pcasr_pkg for default widths.
`timescale 1ns / 1ps
module pcasr_div #(
  parameter int NW = pcasr_pkg::DIV_NW,
  parameter int DW = pcasr_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r, dvs_r;
  logic [DW:0]   shifted, trial;
  logic          take;

  // One restoring step
  assign shifted = {rem_r, quo_r[NW-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign take    = (shifted >= {1'b0, dvs_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? trial[DW-1:0] : shifted[DW-1:0];
      quo_r <= {quo_r[NW-2:0], take};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// ----- hw/rtl/pcasr_lat_store.sv -----
// pcasr_lat_store: regression weight and latent offset memories, cleared at reset
// through per-entry valid bits. Depends on pcasr_pkg.
`timescale 1ns / 1ps
module pcasr_lat_store #(
  parameter int MC = pcasr_pkg::MAX_COMPONENTS_DEF,
  parameter int NM = pcasr_pkg::NUM_MEASUREMENTS_DEF,
  localparam int W_DEPTH = MC * NM,
  localparam int W_AW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1,
  localparam int O_AW = (MC > 1) ? $clog2(MC) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              w_we,
  input  logic [W_AW-1:0]                   w_waddr,
  input  logic                              o_we,
  input  logic [O_AW-1:0]                   o_waddr,
  input  logic [pcasr_pkg::DATA_W-1:0]      wdata,
  input  logic                              w_re,
  input  logic [W_AW-1:0]                   w_raddr,
  input  logic                              o_re,
  input  logic [O_AW-1:0]                   o_raddr,
  output logic [pcasr_pkg::DATA_W-1:0]      w_rdata,
  output logic [pcasr_pkg::DATA_W-1:0]      o_rdata
);
  import pcasr_pkg::*;

  logic [DATA_W-1:0] w_mem [W_DEPTH];
  logic [DATA_W-1:0] o_mem [MC];
  logic [W_DEPTH-1:0] w_vld_r;
  logic [MC-1:0]      o_vld_r;
  logic [DATA_W-1:0] w_q_r, o_q_r;
  logic              w_qv_r, o_qv_r;

  // Memory arrays
  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= wdata;
    end
    if (o_we) begin
      o_mem[o_waddr] <= wdata;
    end
    if (w_re) begin
      w_q_r <= w_mem[w_raddr];
    end
    if (o_re) begin
      o_q_r <= o_mem[o_raddr];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= '0;
      o_vld_r <= '0;
      w_qv_r  <= 1'b0;
      o_qv_r  <= 1'b0;
    end else begin
      if (w_we) begin
        w_vld_r[w_waddr] <= 1'b1;
      end
      if (o_we) begin
        o_vld_r[o_waddr] <= 1'b1;
      end
      if (w_re) begin
        w_qv_r <= w_vld_r[w_raddr];
      end
      if (o_re) begin
        o_qv_r <= o_vld_r[o_raddr];
      end
    end
  end

  assign w_rdata = w_qv_r ? w_q_r : '0;
  assign o_rdata = o_qv_r ? o_q_r : '0;
endmodule

// ----- hw/rtl/pcasr_shape_store.sv -----
// pcasr_shape_store: basis and mean shape memories, one write and one registered read each.
// Depends on pcasr_pkg.
`timescale 1ns / 1ps
module pcasr_shape_store #(
  parameter int MC = pcasr_pkg::MAX_COMPONENTS_DEF,
  parameter int MV = pcasr_pkg::MAX_VERTICES_DEF,
  localparam int B_DEPTH = 3 * MV * MC,
  localparam int R_DEPTH = 3 * MV,
  localparam int B_AW = $clog2(B_DEPTH),
  localparam int R_AW = $clog2(R_DEPTH)
) (
  input  logic                         clk,
  input  logic                         b_we,
  input  logic [B_AW-1:0]              b_waddr,
  input  logic                         m_we,
  input  logic [R_AW-1:0]              m_waddr,
  input  logic [pcasr_pkg::DATA_W-1:0] wdata,
  input  logic                         b_re,
  input  logic [B_AW-1:0]              b_raddr,
  input  logic                         m_re,
  input  logic [R_AW-1:0]              m_raddr,
  output logic [pcasr_pkg::DATA_W-1:0] b_rdata,
  output logic [pcasr_pkg::DATA_W-1:0] m_rdata
);
  import pcasr_pkg::*;

  logic [DATA_W-1:0] b_mem [B_DEPTH];
  logic [DATA_W-1:0] m_mem [R_DEPTH];
  logic [DATA_W-1:0] b_q_r, m_q_r;

  // Basis memory
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= wdata;
    end
    if (b_re) begin
      b_q_r <= b_mem[b_raddr];
    end
  end

  // Mean shape memory
  always_ff @(posedge clk) begin
    if (m_we) begin
      m_mem[m_waddr] <= wdata;
    end
    if (m_re) begin
      m_q_r <= m_mem[m_raddr];
    end
  end

  assign b_rdata = b_q_r;
  assign m_rdata = m_q_r;
endmodule

// ----- hw/rtl/pca_shape_reconstruction.sv -----
// pca_shape_reconstruction: top level, query sequencer, multiply-accumulate datapath
// and configuration registers. Depends on pcasr_pkg, pcasr_div, pcasr_lat_store,
// pcasr_shape_store.
//
// Usage: the in_ channel carries load and query requests, the kind in in_tuser.
// Loads of weights, offsets, basis rows and mean rows are written in the cycle
// they are accepted. A query of a vertex below MAX_VERTICES
// yields one request on the out_ channel with x, y, z; other requests give none.
// A query runs on one read port per memory, a bit-serial divider for the
// measurement ratios (DIV_NW steps per ratio) and a reciprocal division by
// ten per axis; in_tready stays low until the query hands its result to the
// output register, which raises out_tvalid.
// The result sits in an output register; the next request is taken while it
// waits, and a following query holds in its last step until out_tready frees it.
// Reset restores the measurement registers and clears weights and offsets;
// basis and mean entries must be written before a query reads them.
// The cfg_ port is always ready; write it only while no query is in flight.
`timescale 1ns / 1ps
module pca_shape_reconstruction #(
  parameter int MAX_COMPONENTS   = pcasr_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_VERTICES     = pcasr_pkg::MAX_VERTICES_DEF,
  parameter int NUM_MEASUREMENTS = pcasr_pkg::NUM_MEASUREMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] row_index, [20:16] col_index, [52:21] value, [55:53] zero
  input  logic [pcasr_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] kind
  input  logic [pcasr_pkg::KIND_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
  output logic [pcasr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcasr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcasr_pkg::REG_W-1:0]       cfg_data
);
  import pcasr_pkg::*;

  localparam int MC = MAX_COMPONENTS;
  localparam int MV = MAX_VERTICES;
  localparam int NM = NUM_MEASUREMENTS;
  localparam int W_AW = (MC * NM > 1) ? $clog2(MC * NM) : 1;
  localparam int C_W  = (MC > 1) ? $clog2(MC) : 1;
  localparam int J_W  = (NM > 1) ? $clog2(NM) : 1;
  localparam int V_W  = $clog2(MV);
  localparam int B_AW = $clog2(3 * MV * MC);
  localparam int R_AW = $clog2(3 * MV);

  // Input fields
  kind_t                   in_kind;
  logic [ROW_W-1:0]        in_row;
  logic [COL_W-1:0]        in_col;
  logic [DATA_W-1:0]       in_value;
  assign in_kind  = kind_t'(in_tuser);
  assign in_row   = in_tdata[15:0];
  assign in_col   = in_tdata[20:16];
  assign in_value = in_tdata[52:21];

  // Registers
  state_t                   state_r, state_nxt;
  logic [REG_W-1:0]         regs_r [REG_COUNT];
  logic [J_W-1:0]           j_r, j_nxt;
  logic [C_W-1:0]           c_r, c_nxt;
  logic [1:0]               k_r, k_nxt;
  logic [V_W-1:0]           vtx_r, vtx_nxt;
  logic [RATIO_W-1:0]       ratio_r [NM];
  logic [RATIO_W-1:0]       ratio_nxt [NM];
  logic signed [WPROD_W-1:0] wprod_r, wprod_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [DATA_W-1:0] lat_r, lat_nxt;
  logic signed [63:0]       bprod_r, bprod_nxt;
  logic signed [ACC_W-1:0]  acc_r [3];
  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic signed [S_W-1:0]    s_r, s_nxt;
  logic signed [P_W-1:0]    p_r, p_nxt;
  logic                     neg_r, neg_nxt;
  logic [DATA_W-1:0]        qh_r, qh_nxt;
  logic [QT_W-1:0]          qt_r, qt_nxt;
  logic [DATA_W-1:0]        pos_r [3];
  logic [DATA_W-1:0]        pos_nxt [3];
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]    out_tdata_r, out_tdata_nxt;

  // Combinational helpers
  logic                     in_ready_c;
  logic                     in_acc;
  logic                     wt_ok, off_ok, bas_ok, mean_ok, vtx_ok;
  logic [REG_W-1:0]         height;
  logic signed [SUM_W-1:0]  lat_sum;
  logic signed [63:0]       bsh;
  logic signed [ACC_W-1:0]  s_full;
  logic [P_W-1:0]           p_mag;
  logic [QX_W-1:0]          qx;
  logic [QP_W-1:0]          qt_prod;
  logic [DATA_W-1:0]        quo;
  logic signed [DATA_W:0]   q_signed;

  // Memory and divider connections
  logic w_we, o_we, b_we, m_we, w_re, o_re, b_re, m_re;
  logic [W_AW-1:0]   w_waddr, w_raddr;
  logic [C_W-1:0]    o_waddr;
  logic [B_AW-1:0]   b_waddr, b_raddr;
  logic [R_AW-1:0]   m_waddr, m_raddr;
  logic [DATA_W-1:0] w_rdata, o_rdata, b_rdata, m_rdata;
  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_dividend, div_quo;
  logic [DIV_DW-1:0] div_divisor;

  assign height = regs_r[REG_HEIGHT];
  assign in_acc = in_tvalid && in_ready_c;

  // Load range checks
  assign wt_ok   = (17'(in_row) < 17'(MC)) && (in_col < COL_W'(NM));
  assign off_ok  = (17'(in_row) < 17'(MC));
  assign bas_ok  = (18'(in_row) < 18'(3 * MV)) && (7'(in_col) < 7'(MC));
  assign mean_ok = (18'(in_row) < 18'(3 * MV));
  assign vtx_ok  = (17'(in_row) < 17'(MV));

  // Addresses
  assign w_waddr = W_AW'(in_row) * W_AW'(NM) + W_AW'(in_col);
  assign o_waddr = C_W'(in_row);
  assign b_waddr = B_AW'(in_row) * B_AW'(MC) + B_AW'(in_col);
  assign m_waddr = R_AW'(in_row);
  assign w_raddr = W_AW'(c_r) * W_AW'(NM) + W_AW'(j_r);
  assign m_raddr = R_AW'(vtx_r) * R_AW'(3) + R_AW'(k_r);
  assign b_raddr = B_AW'(m_raddr) * B_AW'(MC) + B_AW'(c_r);

  // Datapath arithmetic
  assign lat_sum  = (sum_r >>> 16) + $signed({{(SUM_W-DATA_W){o_rdata[DATA_W-1]}}, o_rdata});
  assign bsh      = bprod_r >>> 16;
  assign s_full   = acc_r[k_r] + $signed({{(ACC_W-DATA_W){m_rdata[DATA_W-1]}}, m_rdata});
  assign p_mag    = p_r[P_W-1] ? (P_W'(FLOOR_BIAS) - p_r) : p_r;

  // Division by ten: clamp, split at bit 16, reciprocal on the small remainder part
  assign qx       = (p_mag[P_W-1:QX_W] != '0) ? {QX_W{1'b1}} : p_mag[QX_W-1:0];
  assign qt_prod  = QP_W'(qt_r) * QP_W'(DIV10_RCP);
  assign quo      = qh_r + DATA_W'(qt_prod[QP_W-1:DIV10_SH]);
  assign q_signed = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  pcasr_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .done(div_done), .quotient(div_quo)
  );

  pcasr_lat_store #(.MC(MC), .NM(NM)) u_lat_store (
    .clk(clk), .rst_n(rst_n),
    .w_we(w_we), .w_waddr(w_waddr), .o_we(o_we), .o_waddr(o_waddr), .wdata(in_value),
    .w_re(w_re), .w_raddr(w_raddr), .o_re(o_re), .o_raddr(c_r),
    .w_rdata(w_rdata), .o_rdata(o_rdata)
  );

  pcasr_shape_store #(.MC(MC), .MV(MV)) u_shape_store (
    .clk(clk),
    .b_we(b_we), .b_waddr(b_waddr), .m_we(m_we), .m_waddr(m_waddr), .wdata(in_value),
    .b_re(b_re), .b_raddr(b_raddr), .m_re(m_re), .m_raddr(m_raddr),
    .b_rdata(b_rdata), .m_rdata(m_rdata)
  );

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    j_nxt          = j_r;
    c_nxt          = c_r;
    k_nxt          = k_r;
    vtx_nxt        = vtx_r;
    ratio_nxt      = ratio_r;
    wprod_nxt      = wprod_r;
    sum_nxt        = sum_r;
    lat_nxt        = lat_r;
    bprod_nxt      = bprod_r;
    acc_nxt        = acc_r;
    s_nxt          = s_r;
    p_nxt          = p_r;
    neg_nxt        = neg_r;
    qh_nxt         = qh_r;
    qt_nxt         = qt_r;
    pos_nxt        = pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    in_ready_c     = 1'b0;
    w_we = 1'b0; o_we = 1'b0; b_we = 1'b0; m_we = 1'b0;
    w_re = 1'b0; o_re = 1'b0; b_re = 1'b0; m_re = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      S_IDLE: begin
        in_ready_c = 1'b1;
        if (in_tvalid) begin
          case (in_kind)
            KIND_WEIGHT: w_we = wt_ok;
            KIND_OFFSET: o_we = off_ok;
            KIND_BASIS:  b_we = bas_ok;
            KIND_MEAN:   m_we = mean_ok;
            KIND_QUERY: begin
              if (vtx_ok) begin
                vtx_nxt   = V_W'(in_row);
                j_nxt     = '0;
                acc_nxt   = '{default: '0};
                state_nxt = S_RATIO_GO;
              end
            end
            default: ;
          endcase
        end
      end
      // Measurement ratios through the serial divider
      S_RATIO_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_NW'({regs_r[3'(j_r)], 16'h0000});
        div_divisor  = height;
        state_nxt    = S_RATIO_WAIT;
      end
      S_RATIO_WAIT: begin
        if (div_done) begin
          ratio_nxt[j_r] = (height == '0) ? '0 : div_quo[RATIO_W-1:0];
          if (j_r == J_W'(NM - 1)) begin
            j_nxt     = '0;
            c_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = S_W_RD;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_RATIO_GO;
          end
        end
      end
      // Latent component: weights times ratios
      S_W_RD: begin
        w_re      = 1'b1;
        state_nxt = S_W_MUL;
      end
      S_W_MUL: begin
        wprod_nxt = $signed(w_rdata) * $signed({1'b0, ratio_r[j_r]});
        state_nxt = S_W_ACC;
      end
      S_W_ACC: begin
        sum_nxt = sum_r + $signed({{(SUM_W-WPROD_W){wprod_r[WPROD_W-1]}}, wprod_r});
        if (j_r == J_W'(NM - 1)) begin
          state_nxt = S_E_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_W_RD;
        end
      end
      S_E_RD: begin
        o_re      = 1'b1;
        state_nxt = S_E_ADD;
      end
      S_E_ADD: begin
        lat_nxt   = sat32(lat_sum);
        k_nxt     = '0;
        state_nxt = S_B_RD;
      end
      // Basis rows times this latent component, three axes
      S_B_RD: begin
        b_re      = 1'b1;
        state_nxt = S_B_MUL;
      end
      S_B_MUL: begin
        bprod_nxt = $signed(b_rdata) * lat_r;
        state_nxt = S_B_ACC;
      end
      S_B_ACC: begin
        acc_nxt[k_r] = acc_r[k_r] + bsh[ACC_W-1:0];
        if (k_r == 2'd2) begin
          k_nxt = '0;
          if (c_r == C_W'(MC - 1)) begin
            state_nxt = S_M_RD;
          end else begin
            c_nxt     = c_r + 1'b1;
            j_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = S_W_RD;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_B_RD;
        end
      end
      // Mean, height scale and floor division by ten per axis
      S_M_RD: begin
        m_re      = 1'b1;
        state_nxt = S_M_ADD;
      end
      S_M_ADD: begin
        if (s_full[ACC_W-1:S_W-1] != {(ACC_W-S_W+1){s_full[ACC_W-1]}}) begin
          s_nxt = s_full[ACC_W-1] ? {1'b1, {(S_W-1){1'b0}}} : {1'b0, {(S_W-1){1'b1}}};
        end else begin
          s_nxt = s_full[S_W-1:0];
        end
        state_nxt = S_H_MUL;
      end
      S_H_MUL: begin
        p_nxt     = s_r * $signed({1'b0, height});
        state_nxt = S_Q_GO;
      end
      S_Q_GO: begin
        qh_nxt    = DATA_W'(qx[QX_W-1:16]) * DATA_W'(DIV10_HI);
        qt_nxt    = QT_W'(qx[QX_W-1:16]) * QT_W'(DIV10_REM) + QT_W'(qx[15:0]);
        neg_nxt   = p_r[P_W-1];
        state_nxt = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        pos_nxt[k_r] = sat32($signed({{(63-DATA_W){q_signed[DATA_W]}}, q_signed}));
        if (k_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_M_RD;
        end
      end
      // Hand the result to the output register
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {pos_r[2], pos_r[1], pos_r[0]};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      j_r          <= '0;
      c_r          <= '0;
      k_r          <= '0;
      regs_r       <= REG_RESET;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      j_r          <= j_nxt;
      c_r          <= c_nxt;
      k_r          <= k_nxt;
      if (cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
        regs_r[cfg_index[2:0]] <= cfg_data & REG_MASK[cfg_index[2:0]];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    vtx_r       <= vtx_nxt;
    ratio_r     <= ratio_nxt;
    wprod_r     <= wprod_nxt;
    sum_r       <= sum_nxt;
    lat_r       <= lat_nxt;
    bprod_r     <= bprod_nxt;
    acc_r       <= acc_nxt;
    s_r         <= s_nxt;
    p_r         <= p_nxt;
    neg_r       <= neg_nxt;
    qh_r        <= qh_nxt;
    qt_r        <= qt_nxt;
    pos_r       <= pos_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = in_ready_c;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  // Checks
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_QUERY && vtx_ok) |=> !in_tready)
    else $error("input still ready after a query was taken");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind != KIND_QUERY) |=> in_tready)
    else $error("load request left the block busy");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_no_mem_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !(w_we || o_we || b_we || m_we))
    else $error("table write during a query");
endmodule

// ----- tb/pcasr_checker.sv -----
// pcasr_checker: watches the request, result and register channels of the PCA shape
// reconstruction block, predicts each vertex position and compares it with the result.
// Depends on pcasr_pkg for kinds, widths and register masks.
`timescale 1ns / 1ps
module pcasr_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [pcasr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [pcasr_pkg::KIND_W-1:0]      in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [pcasr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pcasr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcasr_pkg::REG_W-1:0]       cfg_data,
  output int                                errors,
  output int                                pending
);
  import pcasr_pkg::*;

  localparam int NCOMP = MAX_COMPONENTS_DEF;
  localparam int NVERT = MAX_VERTICES_DEF;
  localparam int NMEAS = NUM_MEASUREMENTS_DEF;
  localparam int NROWS = 3 * NVERT;

  // Shadow copy of the block state
  logic [REG_W-1:0] meas_regs [REG_COUNT];
  int               weights [NCOMP*NMEAS];
  int               offsets [NCOMP];
  int               basis_rows [int];
  int               mean_rows [int];
  logic [OUT_DATA_W-1:0] expected_pos [$];

  function automatic int clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // x, y, z of one vertex from the current tables and measurements
  function automatic logic [OUT_DATA_W-1:0] vertex_position(input int v);
    longint ratio [NMEAS];
    int     latent [NCOMP];
    longint h, sum, acc, s, p;
    int     r;
    logic [OUT_DATA_W-1:0] pos;
    h = longint'(meas_regs[REG_HEIGHT]);
    for (int j = 0; j < NMEAS; j++)
      ratio[j] = (h == 0) ? 0 : (longint'(meas_regs[j]) <<< 16) / h;
    for (int c = 0; c < NCOMP; c++) begin
      sum = 0;
      for (int j = 0; j < NMEAS; j++)
        sum += longint'(weights[c*NMEAS+j]) * ratio[j];
      latent[c] = clamp32((sum >>> 16) + longint'(offsets[c]));
    end
    for (int k = 0; k < 3; k++) begin
      r = v * 3 + k;
      acc = 0;
      for (int c = 0; c < NCOMP; c++)
        if (basis_rows.exists(r*NCOMP+c))
          acc += (longint'(basis_rows[r*NCOMP+c]) * longint'(latent[c])) >>> 16;
      s = acc + (mean_rows.exists(r) ? longint'(mean_rows[r]) : 0);
      p = s * h;
      p = (p >= 0) ? p / 10 : -((-p + 9) / 10);
      pos[k*32 +: 32] = clamp32(p);
    end
    return pos;
  endfunction

  // Track requests, register writes and results
  always @(posedge clk) begin
    int row, col, val;
    logic [OUT_DATA_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) meas_regs[i] = REG_RESET[i];
      for (int i = 0; i < NCOMP*NMEAS; i++) weights[i] = 0;
      for (int i = 0; i < NCOMP; i++) offsets[i] = 0;
      basis_rows.delete();
      mean_rows.delete();
      expected_pos.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < REG_COUNT)
        meas_regs[cfg_index] = cfg_data & REG_MASK[cfg_index];
      if (in_tvalid && in_tready) begin
        row = int'(in_tdata[15:0]);
        col = int'(in_tdata[20:16]);
        val = int'(in_tdata[52:21]);
        case (in_tuser)
          KIND_WEIGHT: if (row < NCOMP && col < NMEAS) weights[row*NMEAS+col] = val;
          KIND_OFFSET: if (row < NCOMP) offsets[row] = val;
          KIND_BASIS:  if (row < NROWS && col < NCOMP) basis_rows[row*NCOMP+col] = val;
          KIND_MEAN:   if (row < NROWS) mean_rows[row] = val;
          KIND_QUERY:  if (row < NVERT) expected_pos.push_back(vertex_position(row));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_pos.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = expected_pos.pop_front();
          for (int k = 0; k < 3; k++)
            if (out_tdata[k*32 +: 32] !== want[k*32 +: 32]) begin
              errors++;
              if (errors <= 10)
                $display("axis %0d mismatch: expected %h got %h", k,
                         want[k*32 +: 32], out_tdata[k*32 +: 32]);
            end
        end
      end
      pending = expected_pos.size();
    end
  end

endmodule

// ----- tb/tb_pca_shape_reconstruction.sv -----
// tb_pca_shape_reconstruction: drives loads, queries and register settings into the
// PCA shape reconstruction block and gives the verdict. Depends on pcasr_pkg,
// pcasr_checker and the block itself.
`timescale 1ns / 1ps
module tb_pca_shape_reconstruction;
  import pcasr_pkg::*;

  localparam longint CYCLE_LIMIT = 5_000_000;
  localparam int     DRAIN = 2000;
  localparam int     NVERT = MAX_VERTICES_DEF;
  localparam int     NCOMP = MAX_COMPONENTS_DEF;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;  // [15:0] row, [20:16] col, [52:21] value
  logic [KIND_W-1:0] in_tuser = '0;     // [2:0] kind
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;     // [31:0] x, [63:32] y, [95:64] z
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  int errors, pending;
  longint cycles = 0;
  bit sender_steady = 0;
  int loaded_vertices [$];

  always #5 clk = ~clk;

  pca_shape_reconstruction u_top (.*);

  pcasr_checker u_checker (.*);

  // Result side backpressure, with a quiet window
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= (cycles > 60000 && cycles < 120000) || ($urandom_range(99) >= 27);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pca_shape_reconstruction: FAIL");
      $finish;
    end
  end

  task automatic send(input logic [KIND_W-1:0] kind, input int row, input int col,
                      input int val);
    if (!sender_steady && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, val[31:0], col[4:0], row[15:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic reg_write(input int idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= data[REG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and let every query finish
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic int table_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return int'($urandom_range(1 << 19)) - (1 << 18);
    endcase
  endfunction

  // Every basis and mean row of one vertex, so it may be queried
  task automatic load_vertex(input int v);
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < NCOMP; c++) send(KIND_BASIS, v*3+k, c, table_value());
      send(KIND_MEAN, v*3+k, $urandom_range(31), table_value());
    end
    loaded_vertices.push_back(v);
  endtask

  task automatic random_request();
    int r, v;
    r = $urandom_range(99);
    v = loaded_vertices[$urandom_range(loaded_vertices.size()-1)];
    if (r < 30)      send(KIND_QUERY, v, $urandom_range(31), $urandom);
    else if (r < 34) send(KIND_QUERY, $urandom_range(65535, NVERT), $urandom_range(31), $urandom);
    else if (r < 50) send(KIND_BASIS, v*3 + $urandom_range(2), $urandom_range(31), table_value());
    else if (r < 58) send(KIND_MEAN, v*3 + $urandom_range(2), $urandom_range(31), table_value());
    else if (r < 68) send(KIND_WEIGHT, $urandom_range(31), $urandom_range(6), table_value());
    else if (r < 71) send(KIND_WEIGHT, $urandom_range(65535), $urandom_range(31), table_value());
    else if (r < 79) send(KIND_OFFSET, $urandom_range(31), $urandom_range(31), table_value());
    else if (r < 82) send(KIND_OFFSET, $urandom_range(65535), $urandom_range(31), table_value());
    else if (r < 88) send(KIND_BASIS, $urandom_range(65535), $urandom_range(31), table_value());
    else if (r < 94) send(KIND_MEAN, $urandom_range(65535), $urandom_range(31), table_value());
    else send(3'($urandom_range(7, 5)), $urandom_range(65535), $urandom_range(31), $urandom);
  endtask

  initial begin
    int low_set [REG_COUNT] = '{790, 700, 520, 790, 290, 650, 290, 1450};
    int high_set [REG_COUNT] = '{1130, 1010, 1130, 1130, 450, 950, 600, 2010};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, ignored loads, unused kinds, out-of-range vertices
    send(KIND_WEIGHT, 0, 0, 32'sh7FFF_FFFF);
    send(KIND_WEIGHT, 31, 6, 32'sh8000_0000);
    send(KIND_WEIGHT, 3, 7, 32'sh1234_5678);
    send(KIND_WEIGHT, 32, 0, 32'sh1234_5678);
    send(KIND_OFFSET, 0, 0, 32'sh0001_0000);
    send(KIND_OFFSET, 31, 0, 32'sh8000_0000);
    send(KIND_OFFSET, 65535, 31, 32'sh7FFF_FFFF);
    send(KIND_BASIS, 49152, 0, 32'sh7FFF_FFFF);
    send(KIND_MEAN, 65535, 0, 32'sh7FFF_FFFF);
    send(3'd5, 0, 0, 0);
    send(3'd6, 65535, 31, -1);
    send(3'd7, 1, 1, 1);
    send(KIND_QUERY, NVERT, 0, 0);
    send(KIND_QUERY, 65535, 31, -1);
    load_vertex(0);
    load_vertex(NVERT - 1);
    load_vertex($urandom_range(NVERT - 2, 1));
    send(KIND_QUERY, 0, 0, 0);
    send(KIND_QUERY, NVERT - 1, 0, 0);

    // Phases: reset values, lows, highs, random masked, zero height
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        drain();
        for (int i = 0; i < REG_COUNT; i++)
          case (phase)
            1: reg_write(i, low_set[i]);
            2: reg_write(i, high_set[i]);
            3: reg_write(i, $urandom_range(2047));
            default: reg_write(i, (i == REG_HEIGHT) ? 0 : 2047);
          endcase
        reg_write($urandom_range(15, REG_COUNT), $urandom_range(2047));
      end
      sender_steady = (phase == 2);
      if (phase == 3) load_vertex($urandom_range(NVERT - 2, 1));
      for (int n = 0; n < 60; n++) random_request();
    end

    drain();
    if (errors == 0) begin
      $display("tb_pca_shape_reconstruction: PASS");
    end else begin
      $display("tb_pca_shape_reconstruction: FAIL");
    end
    $finish;
  end

endmodule
